[rtl/fdp_pkg.sv]
// Package for the frame downscale and pack block: widths, register indexes,
// item kinds, queue entry type and the scaling constants.
// No dependencies; every other file of the block but fdp_ram imports it.
package fdp_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 131072;

  localparam int unsigned ADDR_W    = 17;  // item address field
  localparam int unsigned PIX_W     = 8;   // grayscale pixel
  localparam int unsigned DIM_W     = 11;  // source width and height registers
  localparam int unsigned SRC_AW    = 23;  // wide enough for row * width + column
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Y_W       = 7;   // display row, at most 127
  localparam int unsigned X_W       = 8;   // display column, at most 239
  localparam int unsigned CNT_W     = 3;   // pixel counter within one byte

  // Packed image sizes in bytes.
  localparam int unsigned MONO_BYTES = 1024;
  localparam int unsigned GRAY_BYTES = 7680;

  localparam int unsigned MONO_THRESHOLD = 128;
  localparam int unsigned GRAY_W         = 240;
  localparam int unsigned MONO_W_SHIFT   = 7;  // 128 columns
  localparam int unsigned MONO_H_SHIFT   = 6;  // 64 rows
  localparam int unsigned GRAY_H_SHIFT   = 7;  // 128 rows

  // n / 15 == (n * RECIP15) >> RECIP_SHIFT for every n below 74898.
  localparam int unsigned RECIP15     = 34953;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [CNT_W-1:0] MONO_PIX_LAST = CNT_W'(7);
  localparam logic [CNT_W-1:0] GRAY_PIX_LAST = CNT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ITEM_WRITE = 2'd0,
    ITEM_READ  = 2'd1,
    ITEM_FAIL  = 2'd2
  } item_e;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_ROW    = 3'd1,
    BK_BASE   = 3'd2,
    BK_STREAM = 3'd3,
    BK_DRAIN  = 3'd4,
    BK_DONE   = 3'd5
  } bk_state_e;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    item_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic [Y_W-1:0]    row;
    logic [X_W-1:0]    col0;
  } entry_t;

endpackage

[rtl/fdp_channels.sv]
// Valid/ready channel interfaces for the command items and the result items.
// Depends on fdp_pkg.
interface fdp_cmd_if import fdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [PIX_W-1:0]  pixel_value;

  modport source(output valid, command, address, pixel_value, input ready);
  modport sink(input valid, command, address, pixel_value, output ready);
endinterface

interface fdp_res_if import fdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] packed_byte;
  logic             error;

  modport source(output valid, packed_byte, error, input ready);
  modport sink(input valid, packed_byte, error, output ready);
endinterface

[rtl/fdp_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module fdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/fdp_front.sv]
// Front end: accepts command items, range-checks them and works out the display
// row and first column of a read, then pushes a classified entry to the queue.
// Depends on fdp_pkg and fdp_channels.
module fdp_front import fdp_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  fdp_cmd_if.sink    cmd_i,
  input  cfg_t       cfg_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  logic                 size_ok;
  logic                 read_ok;
  logic                 write_ok;
  logic [Y_W-1:0]       row;
  logic [X_W-1:0]       col0;
  logic [10:0]          quad;
  logic [26:0]          quad_prod;
  logic [Y_W-1:0]       gray_row;
  logic [14:0]          gray_p0;
  logic [14:0]          gray_row_start;

  assign cmd_i.ready = q_ready_i;
  assign q_push_o    = cmd_i.valid && q_ready_i;

  // In the gray mode a byte holds four pixels; its first pixel p0 = 4 * index
  // lies on row p0 / 240, computed as (index / 4) / 15 by a reciprocal.
  assign quad           = cmd_i.address[12:2];
  assign quad_prod      = 27'(quad) * 27'(RECIP15);
  assign gray_row       = Y_W'(quad_prod >> RECIP_SHIFT);
  assign gray_p0        = {cmd_i.address[12:0], 2'b00};
  assign gray_row_start = (15'(gray_row) << 8) - (15'(gray_row) << 4);

  always_comb begin
    size_ok  = (cfg_i.width != '0) && (cfg_i.height != '0);
    write_ok = SRC_AW'(cmd_i.address) < SRC_AW'(FRAME_DEPTH);
    if (cfg_i.mode) begin
      read_ok = size_ok && (cmd_i.address < ADDR_W'(GRAY_BYTES));
      row     = gray_row;
      col0    = X_W'(gray_p0 - gray_row_start);
    end else begin
      read_ok = size_ok && (cmd_i.address < ADDR_W'(MONO_BYTES));
      row     = Y_W'(cmd_i.address[9:4]);
      col0    = {1'b0, cmd_i.address[3:0], 3'b000};
    end

    q_entry_o.addr  = cmd_i.address;
    q_entry_o.pixel = cmd_i.pixel_value;
    q_entry_o.row   = row;
    q_entry_o.col0  = col0;
    if (cmd_i.command) begin
      q_entry_o.kind = read_ok ? ITEM_READ : ITEM_FAIL;
    end else begin
      q_entry_o.kind = write_ok ? ITEM_WRITE : ITEM_FAIL;
    end
  end

endmodule

[rtl/fdp_queue.sv]
// Two-entry queue of classified items between the front and the back end.
// Depends on fdp_pkg.
module fdp_queue import fdp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/fdp_back.sv]
// Back end: owns the frame memory, performs writes, and builds a packed byte
// by streaming its source pixels through a scaling and address pipeline.
// Depends on fdp_pkg, fdp_channels and fdp_ram.
module fdp_back import fdp_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  entry_t     q_head_i,
  output logic       q_pop_o,
  fdp_res_if.source  res_o
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);

  bk_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  pix_last;
  logic              out_free;
  logic              load_res;
  logic [PIX_W-1:0]  res_byte_d;
  logic              res_err_d;
  logic              start_read;
  logic              issue;

  logic [Y_W-1:0]    row_q;
  logic [X_W-1:0]    col0_q;
  logic [17:0]       row_prod;
  logic [DIM_W-1:0]  sy_q, sy_d;
  logic [SRC_AW-1:0] base_q;
  logic [X_W-1:0]    col;

  // Pixel pipeline: product, source column, frame address, read data.
  logic              p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  logic              p1_last_q, p2_last_q, p3_last_q, p4_last_q;
  logic [18:0]       prod_q;
  logic [30:0]       recip_prod;
  logic [DIM_W-1:0]  sx_q, sx_d;
  logic [SRC_AW-1:0] addr_q;
  logic [PIX_W-1:0]  acc_q;
  logic              err_q;

  logic              res_valid_q;
  logic [PIX_W-1:0]  res_byte_q;
  logic              res_err_q;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [SRC_AW-1:0] wr_addr_ext;
  logic [PIX_W-1:0]  ram_rdata;

  fdp_ram #(
    .WIDTH(PIX_W),
    .DEPTH(FRAME_DEPTH)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(q_head_i.pixel),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !res_valid_q || res_o.ready;
  assign pix_last    = cfg_i.mode ? GRAY_PIX_LAST : MONO_PIX_LAST;
  assign wr_addr_ext = SRC_AW'(q_head_i.addr);
  assign ram_addr    = ram_we ? wr_addr_ext[AW-1:0] : addr_q[AW-1:0];

  // Row scaling: the display heights are powers of two, so the division is only a shift.
  assign row_prod = 18'(row_q) * 18'(cfg_i.height);
  assign sy_d     = cfg_i.mode ? DIM_W'(row_prod >> GRAY_H_SHIFT)
                               : DIM_W'(row_prod >> MONO_H_SHIFT);

  assign col = col0_q + X_W'(cnt_q);

  // Column scaling: divide by 128, or by 240 as a shift by four and then a
  // reciprocal multiply for the factor 15. The floor keeps the column below
  // the source width, so no clamp of a row or column is needed.
  assign recip_prod = 31'(prod_q[18:4]) * 31'(RECIP15);
  assign sx_d       = cfg_i.mode ? DIM_W'(recip_prod >> RECIP_SHIFT)
                                 : DIM_W'(prod_q >> MONO_W_SHIFT);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    load_res   = 1'b0;
    res_byte_d = '0;
    res_err_d  = 1'b0;
    start_read = 1'b0;
    issue      = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_head_i.kind)
            ITEM_WRITE: begin
              ram_we   = 1'b1;
              load_res = 1'b1;
            end
            ITEM_READ: begin
              start_read = 1'b1;
              state_d    = BK_ROW;
            end
            default: begin
              load_res  = 1'b1;
              res_err_d = 1'b1;
            end
          endcase
        end
      end
      BK_ROW: begin
        state_d = BK_BASE;
      end
      BK_BASE: begin
        cnt_d   = '0;
        state_d = BK_STREAM;
      end
      BK_STREAM: begin
        issue = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == pix_last) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (p4_v_q && p4_last_q) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          load_res   = 1'b1;
          res_err_d  = err_q;
          res_byte_d = err_q ? '0 : acc_q;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p4_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      p1_v_q  <= issue;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_read) begin
      row_q  <= q_head_i.row;
      col0_q <= q_head_i.col0;
    end
    sy_q      <= sy_d;
    base_q    <= SRC_AW'(22'(sy_q) * 22'(cfg_i.width));
    prod_q    <= 19'(col) * 19'(cfg_i.width);
    p1_last_q <= (cnt_q == pix_last);
    sx_q      <= sx_d;
    p2_last_q <= p1_last_q;
    addr_q    <= base_q + SRC_AW'(sx_q);
    p3_last_q <= p2_last_q;
    p4_last_q <= p3_last_q;

    if (start_read) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (p3_v_q && (addr_q >= SRC_AW'(FRAME_DEPTH))) begin
        err_q <= 1'b1;
      end
      if (p4_v_q) begin
        if (cfg_i.mode) begin
          acc_q <= {acc_q[PIX_W-3:0], ram_rdata[PIX_W-1:PIX_W-2]};
        end else begin
          acc_q <= {acc_q[PIX_W-2:0], (ram_rdata > PIX_W'(MONO_THRESHOLD))};
        end
      end
    end

    if (load_res) begin
      res_byte_q <= res_byte_d;
      res_err_q  <= res_err_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.packed_byte = res_byte_q;
  assign res_o.error       = res_err_q;

endmodule

[rtl/frame_downscale_pack.sv]
// A write or a refused item gives its result from the registered result output once
// the back end has taken it from the queue; a read passes the row and base setup states,
// streams its source pixels through the scaling pipeline, drains it and then loads and
// hands over the result. Throughput: one write per cycle while results are taken, one read at a time.
// Reset: asynchronous, active low; clears the queue, the sequencer and the
// registers to mode 0, 320 x 240. The frame memory is not cleared.
module frame_downscale_pack import fdp_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fdp_cmd_if.sink              cmd_i,
  fdp_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  cfg_t   cfg_q;
  logic   q_push;
  logic   q_ready;
  logic   q_pop;
  logic   q_valid;
  entry_t q_entry;
  entry_t q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.width  <= DIM_W'(320);
      cfg_q.height <= DIM_W'(240);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[0];
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fdp_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_q),
    .q_ready_i(q_ready),
    .q_push_o (q_push),
    .q_entry_o(q_entry)
  );

  fdp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  fdp_back #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .res_o    (res_o)
  );

endmodule

[rtl/fdp_checker.sv]
// Port-level checks for frame_downscale_pack and the bind that attaches them.
// Depends on fdp_pkg and the top level.
module fdp_checker import fdp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_byte_i,
  input logic             out_err_i
);

  // Items accepted whose results have not yet been taken.
  logic [2:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + 3'(in_valid_i && in_ready_i)
                             - 3'(out_valid_i && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
                                    && $stable(out_err_i))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result shown with no item outstanding");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_byte_i == '0)
    else $error("error result carries a nonzero byte");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more items in flight than the block can hold");

endmodule

bind frame_downscale_pack fdp_checker u_fdp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (cmd_i.valid),
  .in_ready_i (cmd_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_byte_i (res_o.packed_byte),
  .out_err_i  (res_o.error)
);
